FILE: design/buffer_slot_ownership_tracker_assert.svh
// assertion macros for the buffer slot ownership tracker
`ifndef BUFFER_SLOT_OWNERSHIP_TRACKER_ASSERT_SVH
`define BUFFER_SLOT_OWNERSHIP_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge out of reset
`define BSOT_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("bsot assertion failed");

// consequent must hold whenever the antecedent holds
`define BSOT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsot implication failed");

`else

`define BSOT_ASSERT(lbl, expr)
`define BSOT_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

FILE: design/bsot_pkg.sv
// shared constants and codes of the buffer slot ownership tracker
`default_nettype none

package bsot_pkg;

  localparam int SLOTS_DEF    = 8;
  localparam int GEN_BITS_DEF = 16;

  localparam int ACTION_W   = 4;
  localparam int SLOT_W     = 3;
  localparam int TAG_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int LIMIT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_LIMIT  = 1'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACQUIRE   = 4'd0,
    ACT_EXPORT    = 4'd1,
    ACT_FINISH    = 4'd2,
    ACT_PRECOMP   = 4'd3,
    ACT_PUBLISH   = 4'd4,
    ACT_COMMIT    = 4'd5,
    ACT_ROLLBACK  = 4'd6,
    ACT_REL_WAIT  = 4'd7,
    ACT_RELEASED  = 4'd8,
    ACT_ABORT     = 4'd9,
    ACT_INSPECT   = 4'd10
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    PH_FREE     = 3'd0,
    PH_RENDER   = 3'd1,
    PH_PRECOMP  = 3'd2,
    PH_EXPORTED = 3'd3,
    PH_HEAD     = 3'd4,
    PH_REPLACED = 3'd5
  } phase_e;

endpackage

`default_nettype wire

FILE: design/bsot_if.sv
// item and result channel interfaces of the buffer slot ownership tracker
`default_nettype none

interface bsot_item_if;
  import bsot_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   slot_index;
  logic [TAG_W-1:0]    generation_tag;
  logic                prev_valid;
  logic [SLOT_W-1:0]   prev_slot;
  logic [TAG_W-1:0]    prev_generation;
  logic                fence_ready;

  modport source (
    output valid, action, slot_index, generation_tag, prev_valid, prev_slot,
           prev_generation, fence_ready,
    input  ready
  );

  modport sink (
    input  valid, action, slot_index, generation_tag, prev_valid, prev_slot,
           prev_generation, fence_ready,
    output ready
  );
endinterface

interface bsot_result_if;
  import bsot_pkg::*;

  logic                valid;
  logic                ready;
  logic                accepted;
  logic [SLOT_W-1:0]   result_slot;
  logic [TAG_W-1:0]    result_generation;
  logic [STATUS_W-1:0] slot_status;
  logic                slot_ready;
  logic                any_free;
  logic                all_free;

  modport source (
    output valid, accepted, result_slot, result_generation, slot_status, slot_ready,
           any_free, all_free,
    input  ready
  );

  modport sink (
    input  valid, accepted, result_slot, result_generation, slot_status, slot_ready,
           any_free, all_free,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/bsot_slot_mem.sv
// slot state memory: one write port, two registered read ports, per-entry valid bits
`default_nettype none

module bsot_slot_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;

  // an entry never written reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= valid_q[raddr_a_i] ? mem[raddr_a_i] : '0;
      rdata_b_o <= valid_q[raddr_b_i] ? mem[raddr_b_i] : '0;
    end
  end

endmodule

`default_nettype wire

FILE: design/buffer_slot_ownership_tracker.sv
// top level of the buffer slot ownership tracker
`default_nettype none
`include "buffer_slot_ownership_tracker_assert.svh"

// Tracks who owns each of SLOTS display buffer slots. Every slot holds a lifecycle phase,
// a GEN_BITS-bit generation tag and a ready-without-fence flag in one slot memory with a
// registered read; a flip-flop free map beside it serves the lowest-free search
// for acquire and the any_free / all_free flags. Handles are checked as slot plus
// generation. Each item is handled as read-modify-write: the accept edge launches the
// memory reads (the granted slot for acquire, the addressed slot otherwise, and the
// previous chain head), then the execute state checks the transition, writes the slot
// back and loads the result register. Commit and rollback that are accepted with a
// previous handle go on to a pair state, since the memory's single write port needs a
// separate write for the previous slot. The execute state waits while the result register
// still holds an untaken result; a new item is taken as soon as the previous one is written
// back, even if its result is still waiting. Refused actions, unknown codes and any action
// while pool_enabled is 0 leave the state as it was. Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_data_i: index 0 is pool_enabled, index 1 is allocation_limit.
module buffer_slot_ownership_tracker #(
  parameter int SLOTS    = bsot_pkg::SLOTS_DEF,
  parameter int GEN_BITS = bsot_pkg::GEN_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bsot_item_if.sink                        item_i,
  bsot_result_if.source                    result_o,
  input  logic                             cfg_we_i,
  input  logic [bsot_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bsot_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bsot_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int EW = GEN_BITS + 4;   // {ready, phase, generation}

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PAIR
  } state_e;

  // configuration registers
  logic               pool_en_q;
  logic [LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_en_q <= 1'b0;
      limit_q   <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_ENABLED: pool_en_q <= cfg_data_i[0];
        CFG_ALLOC_LIMIT:  limit_q   <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  state_e             state_q;
  logic [SLOTS-1:0]   free_q;
  logic [SLOTS-1:0]   free_d;
  logic [SLOTS-1:0]   cand;
  logic [AW-1:0]      lowest;
  logic               acq_hit;
  logic               accept;

  // latched item
  logic [ACTION_W-1:0] act_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [TAG_W-1:0]    tag_q;
  logic                pv_q;
  logic [SLOT_W-1:0]   pslot_q;
  logic [TAG_W-1:0]    ptag_q;
  logic                fr_q;
  logic                found_q;
  logic                in_rng_q;
  logic                p_rng_q;
  logic [AW-1:0]       addr_a_q;
  logic [AW-1:0]       addr_b_q;

  // second write of a pair
  logic [EW-1:0]       pair_data_q;

  // memory ports
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [EW-1:0]       mem_wdata;
  logic [AW-1:0]       rd_addr_a;
  logic [EW-1:0]       rd_a;
  logic [EW-1:0]       rd_b;

  // result register
  logic                out_valid_q;
  logic                out_acc_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [TAG_W-1:0]    out_gen_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_ready_flag_q;
  logic                out_any_q;
  logic                out_all_q;

  // ---------------------------------------------------------------------------
  // acquire candidates: free slots below the allocation limit, lowest wins
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < SLOTS; g++) begin : g_cand
    assign cand[g] = free_q[g] && (32'(g) < 32'(limit_q));
  end

  always_comb begin
    lowest = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        lowest = AW'(i);
      end
    end
  end

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign acq_hit      = pool_en_q && (item_i.action == ACT_ACQUIRE) && (|cand);
  assign rd_addr_a    = acq_hit ? lowest : AW'(item_i.slot_index);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= item_i.action;
      slot_q   <= item_i.slot_index;
      tag_q    <= item_i.generation_tag;
      pv_q     <= item_i.prev_valid;
      pslot_q  <= item_i.prev_slot;
      ptag_q   <= item_i.prev_generation;
      fr_q     <= item_i.fence_ready;
      found_q  <= acq_hit;
      in_rng_q <= 32'(item_i.slot_index) < 32'(SLOTS);
      p_rng_q  <= 32'(item_i.prev_slot) < 32'(SLOTS);
      addr_a_q <= rd_addr_a;
      addr_b_q <= AW'(item_i.prev_slot);
    end
  end

  bsot_slot_mem #(
    .DEPTH (SLOTS),
    .WIDTH (EW)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (accept),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (AW'(item_i.prev_slot)),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // ---------------------------------------------------------------------------
  // execute: check the transition on the read entries
  // ---------------------------------------------------------------------------
  logic [GEN_BITS-1:0] gen_a, gen_b, gen_inc, gen_sum, new_gen;
  logic [STATUS_W-1:0] ph_a, ph_b, new_ph, new_ph_b;
  logic                rdy_a, new_rdy;
  logic                t_ok, p_ok, same_handle, ok, pair, wr_a, fire, show;
  logic [EW-1:0]       new_a;

  assign gen_a = rd_a[GEN_BITS-1:0];
  assign ph_a  = rd_a[GEN_BITS+2:GEN_BITS];
  assign rdy_a = rd_a[GEN_BITS+3];
  assign gen_b = rd_b[GEN_BITS-1:0];
  assign ph_b  = rd_b[GEN_BITS+2:GEN_BITS];

  assign t_ok        = in_rng_q && (gen_a == GEN_BITS'(tag_q));
  assign p_ok        = p_rng_q && (gen_b == GEN_BITS'(ptag_q));
  assign same_handle = (pslot_q == slot_q) && (ptag_q == tag_q);

  // generation wraps and skips zero
  assign gen_sum = gen_a + GEN_BITS'(1);
  assign gen_inc = (gen_sum == '0) ? GEN_BITS'(1) : gen_sum;

  always_comb begin
    ok       = 1'b0;
    pair     = 1'b0;
    new_gen  = gen_a;
    new_ph   = ph_a;
    new_rdy  = rdy_a;
    new_ph_b = ph_b;
    if (pool_en_q) begin
      case (act_q)
        ACT_ACQUIRE: begin
          if (found_q) begin
            ok      = 1'b1;
            new_gen = gen_inc;
            new_ph  = PH_RENDER;
            new_rdy = 1'b0;
          end
        end
        ACT_EXPORT: begin
          if (t_ok && ph_a == PH_RENDER) begin
            ok      = 1'b1;
            new_ph  = PH_EXPORTED;
            new_rdy = 1'b0;
          end
        end
        ACT_FINISH: begin
          if (t_ok && ph_a == PH_RENDER && !rdy_a) begin
            ok      = 1'b1;
            new_ph  = PH_EXPORTED;
            new_rdy = fr_q;
          end
        end
        ACT_PRECOMP: begin
          if (t_ok && ph_a == PH_RENDER && !rdy_a) begin
            ok     = 1'b1;
            new_ph = PH_PRECOMP;
          end
        end
        ACT_PUBLISH: begin
          if (t_ok && ph_a == PH_PRECOMP && !rdy_a) begin
            ok      = 1'b1;
            new_ph  = PH_EXPORTED;
            new_rdy = fr_q;
          end
        end
        ACT_COMMIT: begin
          // previous head must be a different, live chain head
          if (t_ok && ph_a == PH_EXPORTED &&
              (!pv_q || (!same_handle && p_ok && ph_b == PH_HEAD))) begin
            ok       = 1'b1;
            pair     = pv_q;
            new_ph   = PH_HEAD;
            new_ph_b = PH_REPLACED;
          end
        end
        ACT_ROLLBACK: begin
          if (t_ok && ph_a == PH_HEAD && (!pv_q || (p_ok && ph_b == PH_REPLACED))) begin
            ok       = 1'b1;
            pair     = pv_q;
            new_ph   = PH_EXPORTED;
            new_ph_b = PH_HEAD;
          end
        end
        ACT_REL_WAIT: begin
          if (t_ok && ph_a == PH_HEAD) begin
            ok     = 1'b1;
            new_ph = PH_REPLACED;
          end
        end
        ACT_RELEASED: begin
          if (t_ok && (ph_a == PH_HEAD || ph_a == PH_REPLACED)) begin
            ok      = 1'b1;
            new_ph  = PH_FREE;
            new_rdy = 1'b0;
          end
        end
        ACT_ABORT: begin
          if (t_ok && (ph_a == PH_RENDER || ph_a == PH_PRECOMP || ph_a == PH_EXPORTED)) begin
            ok      = 1'b1;
            new_ph  = PH_FREE;
            new_rdy = 1'b0;
          end
        end
        ACT_INSPECT: begin
          ok = in_rng_q;
        end
        default: ;
      endcase
    end
  end

  assign new_a = {new_rdy, new_ph, new_gen};
  assign wr_a  = ok && (act_q != ACT_INSPECT);
  assign fire  = (state_q == ST_EXEC) && (!out_valid_q || result_o.ready);
  assign show  = found_q || in_rng_q;

  // the previous slot only moves between head and replaced, so only slot a can change
  // its free bit
  always_comb begin
    free_d = free_q;
    if (wr_a) begin
      free_d[addr_a_q] = (new_ph == PH_FREE);
    end
  end

  assign mem_we    = (fire && wr_a) || (state_q == ST_PAIR);
  assign mem_waddr = (state_q == ST_PAIR) ? addr_b_q : addr_a_q;
  assign mem_wdata = (state_q == ST_PAIR) ? pair_data_q : new_a;

  always_ff @(posedge clk_i) begin
    if (fire && pair) begin
      pair_data_q <= {rd_b[GEN_BITS+3], new_ph_b, gen_b};
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer with free map and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      free_q           <= '1;
      out_valid_q      <= 1'b0;
      out_acc_q        <= 1'b0;
      out_slot_q       <= '0;
      out_gen_q        <= '0;
      out_status_q     <= '0;
      out_ready_flag_q <= 1'b0;
      out_any_q        <= 1'b0;
      out_all_q        <= 1'b0;
    end else begin
      // a beat taken while a new result loads is replaced by that result
      if (out_valid_q && result_o.ready && !fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state_q          <= pair ? ST_PAIR : ST_IDLE;
            free_q           <= free_d;
            out_valid_q      <= 1'b1;
            out_acc_q        <= ok;
            out_slot_q       <= found_q ? SLOT_W'(addr_a_q) : slot_q;
            out_gen_q        <= show ? TAG_W'(new_gen) : '0;
            out_status_q     <= show ? new_ph : PH_FREE;
            out_ready_flag_q <= show && new_rdy;
            out_any_q        <= pool_en_q && (|free_d);
            out_all_q        <= &free_d;
          end
        end
        ST_PAIR: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.accepted          = out_acc_q;
  assign result_o.result_slot       = out_slot_q;
  assign result_o.result_generation = out_gen_q;
  assign result_o.slot_status       = out_status_q;
  assign result_o.slot_ready        = out_ready_flag_q;
  assign result_o.any_free          = out_any_q;
  assign result_o.all_free          = out_all_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `BSOT_ASSERT_IMP(a_no_write_idle, state_q == ST_IDLE, !mem_we)
  `BSOT_ASSERT_IMP(a_grant_is_free, state_q == ST_EXEC && found_q, free_q[addr_a_q])
  `BSOT_ASSERT_IMP(a_pair_after_exec, state_q == ST_PAIR, $past(state_q) == ST_EXEC)
  `BSOT_ASSERT_IMP(a_pair_distinct, state_q == ST_PAIR, addr_b_q != addr_a_q)
  `BSOT_ASSERT_IMP(a_result_from_exec, $rose(out_valid_q), $past(state_q) == ST_EXEC)

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench for the buffer slot ownership tracker
module testbench;
  import bsot_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = SLOTS_DEF;
  // generous bound on the length of a full run
  localparam int CYCLE_LIMIT = 100_000;
  // action code outside the defined set, must be refused
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 4'd15;

  // one request beat as driven on the item channel
  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot_index;
    logic [TAG_W-1:0]    generation_tag;
    logic                prev_valid;
    logic [SLOT_W-1:0]   prev_slot;
    logic [TAG_W-1:0]    prev_generation;
    logic                fence_ready;
  } slot_req_t;

  // one response beat as seen on the result channel
  typedef struct {
    logic                accepted;
    logic [SLOT_W-1:0]   result_slot;
    logic [TAG_W-1:0]    result_generation;
    logic [STATUS_W-1:0] slot_status;
    logic                slot_ready;
    logic                any_free;
    logic                all_free;
  } slot_outcome_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bsot_item_if   item_if ();
  bsot_result_if result_if ();

  buffer_slot_ownership_tracker u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if.sink),
    .result_o   (result_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the slot table and the two registers
  phase_e           slot_phase_q [NSLOT];
  logic [TAG_W-1:0] slot_gen_q   [NSLOT];
  logic             slot_rdy_q   [NSLOT];
  logic             pool_en_q;
  logic [LIMIT_W-1:0] alloc_lim_q;

  slot_outcome_t pending_outcomes [$];
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            idle_on = 1'b1;   // random gaps on both channels when set

  // ---------------------------------------------------------------------------
  // shadow slot table
  // ---------------------------------------------------------------------------

  // slot number when the handle matches the stored generation, else -1
  function automatic int live_slot(logic [SLOT_W-1:0] s, logic [TAG_W-1:0] tag);
    if (int'(s) >= NSLOT || slot_gen_q[s] != tag) return -1;
    return int'(s);
  endfunction

  // applies one request to the shadow table and returns the response it must cause
  function automatic slot_outcome_t apply_action(slot_req_t r);
    slot_outcome_t o;
    int tgt, prv, lim, rs;
    logic [TAG_W-1:0] g;
    bit okc, hit, anyf, allf;
    o = '{default: '0};
    o.result_slot = r.slot_index;
    tgt = -1;
    prv = -1;
    hit = 1'b0;
    if (pool_en_q) begin
      if (r.action != ACT_ACQUIRE && r.action <= ACT_ABORT)
        tgt = live_slot(r.slot_index, r.generation_tag);
      case (r.action)
        ACT_ACQUIRE: begin
          // limits above the pool size act as the pool size, zero grants nothing
          lim = (int'(alloc_lim_q) < NSLOT) ? int'(alloc_lim_q) : NSLOT;
          for (int i = 0; i < lim; i++) begin
            if (!hit && slot_phase_q[i] == PH_FREE) begin
              g = slot_gen_q[i] + 1'b1;
              if (g == '0) g = TAG_W'(1);   // generation zero is never handed out
              slot_gen_q[i]   = g;
              slot_phase_q[i] = PH_RENDER;
              slot_rdy_q[i]   = 1'b0;
              o.result_slot   = SLOT_W'(i);
              o.accepted      = 1'b1;
              hit             = 1'b1;
            end
          end
        end
        ACT_EXPORT: begin
          if (tgt >= 0 && slot_phase_q[tgt] == PH_RENDER) begin
            slot_rdy_q[tgt]   = 1'b0;
            slot_phase_q[tgt] = PH_EXPORTED;
            o.accepted        = 1'b1;
          end
        end
        ACT_FINISH: begin
          if (tgt >= 0 && slot_phase_q[tgt] == PH_RENDER && !slot_rdy_q[tgt]) begin
            slot_rdy_q[tgt]   = r.fence_ready;
            slot_phase_q[tgt] = PH_EXPORTED;
            o.accepted        = 1'b1;
          end
        end
        ACT_PRECOMP: begin
          if (tgt >= 0 && slot_phase_q[tgt] == PH_RENDER && !slot_rdy_q[tgt]) begin
            slot_phase_q[tgt] = PH_PRECOMP;
            o.accepted        = 1'b1;
          end
        end
        ACT_PUBLISH: begin
          if (tgt >= 0 && slot_phase_q[tgt] == PH_PRECOMP && !slot_rdy_q[tgt]) begin
            slot_rdy_q[tgt]   = r.fence_ready;
            slot_phase_q[tgt] = PH_EXPORTED;
            o.accepted        = 1'b1;
          end
        end
        ACT_COMMIT: begin
          if (tgt >= 0 && slot_phase_q[tgt] == PH_EXPORTED) begin
            okc = 1'b1;
            if (r.prev_valid) begin
              // the previous head may not be the very handle being committed
              if (r.prev_slot == r.slot_index && r.prev_generation == r.generation_tag) begin
                okc = 1'b0;
              end else begin
                prv = live_slot(r.prev_slot, r.prev_generation);
                if (prv < 0 || slot_phase_q[prv] != PH_HEAD) okc = 1'b0;
              end
            end
            if (okc) begin
              slot_phase_q[tgt] = PH_HEAD;
              if (prv >= 0) slot_phase_q[prv] = PH_REPLACED;
              o.accepted = 1'b1;
            end
          end
        end
        ACT_ROLLBACK: begin
          if (tgt >= 0 && slot_phase_q[tgt] == PH_HEAD) begin
            okc = 1'b1;
            if (r.prev_valid) begin
              prv = live_slot(r.prev_slot, r.prev_generation);
              if (prv < 0 || slot_phase_q[prv] != PH_REPLACED) okc = 1'b0;
            end
            if (okc) begin
              slot_phase_q[tgt] = PH_EXPORTED;
              if (prv >= 0) slot_phase_q[prv] = PH_HEAD;
              o.accepted = 1'b1;
            end
          end
        end
        ACT_REL_WAIT: begin
          if (tgt >= 0 && slot_phase_q[tgt] == PH_HEAD) begin
            slot_phase_q[tgt] = PH_REPLACED;
            o.accepted        = 1'b1;
          end
        end
        ACT_RELEASED: begin
          if (tgt >= 0 && (slot_phase_q[tgt] == PH_HEAD || slot_phase_q[tgt] == PH_REPLACED))
          begin
            slot_phase_q[tgt] = PH_FREE;
            slot_rdy_q[tgt]   = 1'b0;
            o.accepted        = 1'b1;
          end
        end
        ACT_ABORT: begin
          if (tgt >= 0 && (slot_phase_q[tgt] == PH_RENDER || slot_phase_q[tgt] == PH_PRECOMP ||
                           slot_phase_q[tgt] == PH_EXPORTED)) begin
            slot_phase_q[tgt] = PH_FREE;
            slot_rdy_q[tgt]   = 1'b0;
            o.accepted        = 1'b1;
          end
        end
        // every 3-bit index names a slot, tag not looked at
        ACT_INSPECT: o.accepted = 1'b1;
        default: ;
      endcase
    end

    anyf = 1'b0;
    allf = 1'b1;
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_phase_q[i] == PH_FREE) anyf = 1'b1;
      else allf = 1'b0;
    end

    rs = int'(o.result_slot);
    o.result_generation = slot_gen_q[rs];
    o.slot_status       = slot_phase_q[rs];
    o.slot_ready        = slot_rdy_q[rs];
    o.any_free          = pool_en_q && anyf;
    o.all_free          = allf;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------

  // request on live handles taken from the shadow table
  function automatic slot_req_t handle_req(action_e act, int s, bit pv, int ps, bit fr);
    slot_req_t r;
    r.action          = act;
    r.slot_index      = SLOT_W'(s);
    r.generation_tag  = slot_gen_q[s];
    r.prev_valid      = pv;
    r.prev_slot       = SLOT_W'(ps);
    r.prev_generation = slot_gen_q[ps];
    r.fence_ready     = fr;
    return r;
  endfunction

  // random slot in the given phase, -1 when there is none
  function automatic int pick_slot_in(phase_e ph);
    int base;
    base = $urandom_range(NSLOT - 1);
    for (int k = 0; k < NSLOT; k++)
      if (slot_phase_q[(base + k) % NSLOT] == ph) return (base + k) % NSLOT;
    return -1;
  endfunction

  // mostly legal lifecycle steps on live handles, the rest noise
  function automatic slot_req_t next_random_req();
    slot_req_t r;
    int s, h;
    r.action          = ACTION_W'($urandom_range(15));
    r.slot_index      = SLOT_W'($urandom_range(NSLOT - 1));
    r.generation_tag  = TAG_W'($urandom_range(16'hFFFF));
    r.prev_valid      = 1'($urandom_range(1));
    r.prev_slot       = SLOT_W'($urandom_range(NSLOT - 1));
    r.prev_generation = TAG_W'($urandom_range(16'hFFFF));
    r.fence_ready     = 1'($urandom_range(1));
    // noise: any code, mostly on live handles so wrong-phase checks are reached
    if ($urandom_range(99) < 25) begin
      if ($urandom_range(3) != 0) r.generation_tag = slot_gen_q[r.slot_index];
      if ($urandom_range(1)) r.prev_generation = slot_gen_q[r.prev_slot];
      return r;
    end
    s = int'(r.slot_index);
    r.prev_valid = 1'b0;
    case (slot_phase_q[s])
      PH_FREE: r.action = ACT_ACQUIRE;
      PH_RENDER: begin
        case ($urandom_range(3))
          0:       r.action = ACT_EXPORT;
          1:       r.action = ACT_FINISH;
          2:       r.action = ACT_PRECOMP;
          default: r.action = ACT_ABORT;
        endcase
      end
      PH_PRECOMP: r.action = ($urandom_range(4) != 0) ? ACT_PUBLISH : ACT_ABORT;
      PH_EXPORTED: begin
        r.action = ($urandom_range(4) != 0) ? ACT_COMMIT : ACT_ABORT;
        h = pick_slot_in(PH_HEAD);
        if (h >= 0 && $urandom_range(3) != 0) begin
          r.prev_valid = 1'b1;
          r.prev_slot  = SLOT_W'(h);
        end
      end
      PH_HEAD: begin
        case ($urandom_range(3))
          0:       r.action = ACT_REL_WAIT;
          1:       r.action = ACT_RELEASED;
          2:       r.action = ACT_INSPECT;
          default: r.action = ACT_ROLLBACK;
        endcase
        h = pick_slot_in(PH_REPLACED);
        if (r.action == ACT_ROLLBACK && h >= 0 && $urandom_range(1)) begin
          r.prev_valid = 1'b1;
          r.prev_slot  = SLOT_W'(h);
        end
      end
      default: begin
        // replaced: either let it go or roll a head back onto it
        h = pick_slot_in(PH_HEAD);
        if (h >= 0 && $urandom_range(1)) begin
          r.action     = ACT_ROLLBACK;
          r.slot_index = SLOT_W'(h);
          r.prev_valid = 1'b1;
          r.prev_slot  = SLOT_W'(s);
        end else begin
          r.action = ACT_RELEASED;
        end
      end
    endcase
    r.generation_tag  = slot_gen_q[r.slot_index];
    r.prev_generation = slot_gen_q[r.prev_slot];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // channel and register drivers
  // ---------------------------------------------------------------------------

  // drive one request beat, predict its response once the beat is taken
  task automatic issue_action(input slot_req_t r);
    if (idle_on && $urandom_range(99) < 9) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    item_if.valid           <= 1'b1;
    item_if.action          <= r.action;
    item_if.slot_index      <= r.slot_index;
    item_if.generation_tag  <= r.generation_tag;
    item_if.prev_valid      <= r.prev_valid;
    item_if.prev_slot       <= r.prev_slot;
    item_if.prev_generation <= r.prev_generation;
    item_if.fence_ready     <= r.fence_ready;
    do @(posedge clk_i); while (!item_if.ready);
    pending_outcomes.push_back(apply_action(r));
  endtask

  // stop sending, wait for every response, then let the pipeline settle
  task automatic drain_outcomes();
    item_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only called while the block is idle
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_POOL_ENABLED) pool_en_q = val[0];
    else alloc_lim_q = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // return every slot to free through the legal exit of its phase
  task automatic clear_pool();
    for (int i = 0; i < NSLOT; i++) begin
      case (slot_phase_q[i])
        PH_RENDER, PH_PRECOMP, PH_EXPORTED: issue_action(handle_req(ACT_ABORT, i, 0, 0, 0));
        PH_HEAD, PH_REPLACED:               issue_action(handle_req(ACT_RELEASED, i, 0, 0, 0));
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // response side: random backpressure and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) result_if.ready <= idle_on ? ($urandom_range(99) >= 9) : 1'b1;

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    slot_outcome_t exp;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("response beat with nothing outstanding");
        mismatches++;
      end else begin
        exp = pending_outcomes.pop_front();
        check_field("accepted", exp.accepted, result_if.accepted);
        check_field("result_slot", exp.result_slot, result_if.result_slot);
        check_field("result_generation", exp.result_generation, result_if.result_generation);
        check_field("slot_status", exp.slot_status, result_if.slot_status);
        check_field("slot_ready", exp.slot_ready, result_if.slot_ready);
        check_field("any_free", exp.any_free, result_if.any_free);
        check_field("all_free", exp.all_free, result_if.all_free);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // out of reset the pool is off, so everything must be refused
  task automatic test_disabled_pool();
    issue_action(handle_req(ACT_ACQUIRE, 0, 0, 0, 0));
    issue_action(handle_req(ACT_INSPECT, NSLOT - 1, 0, 0, 0));
    issue_action(handle_req(ACT_EXPORT, 3, 0, 0, 1));
    drain_outcomes();
  endtask

  // walk each lifecycle path once on a fresh pool
  task automatic test_lifecycle();
    slot_req_t r;
    set_register(CFG_POOL_ENABLED, 4'd1);
    set_register(CFG_ALLOC_LIMIT, 4'd8);
    issue_action(handle_req(ACT_ACQUIRE, 0, 0, 0, 0));
    // stale tag on a live slot
    r = handle_req(ACT_EXPORT, 0, 0, 0, 0);
    r.generation_tag = r.generation_tag + 16'd7;
    issue_action(r);
    issue_action(handle_req(ACT_EXPORT, 0, 0, 0, 0));
    // commit naming itself as the previous head
    issue_action(handle_req(ACT_COMMIT, 0, 1, 0, 0));
    issue_action(handle_req(ACT_COMMIT, 0, 0, 0, 0));
    issue_action(handle_req(ACT_ACQUIRE, 0, 0, 0, 0));
    issue_action(handle_req(ACT_FINISH, 1, 0, 0, 1));
    // swap heads, undo, redo
    issue_action(handle_req(ACT_COMMIT, 1, 1, 0, 0));
    issue_action(handle_req(ACT_ROLLBACK, 1, 1, 0, 0));
    issue_action(handle_req(ACT_COMMIT, 1, 1, 0, 0));
    issue_action(handle_req(ACT_REL_WAIT, 1, 0, 0, 0));
    issue_action(handle_req(ACT_RELEASED, 0, 0, 0, 0));
    issue_action(handle_req(ACT_RELEASED, 1, 0, 0, 0));
    // precompose then publish, and precompose then abort
    issue_action(handle_req(ACT_ACQUIRE, 0, 0, 0, 0));
    issue_action(handle_req(ACT_PRECOMP, 0, 0, 0, 0));
    issue_action(handle_req(ACT_PUBLISH, 0, 0, 0, 1));
    issue_action(handle_req(ACT_ABORT, 0, 0, 0, 0));
    issue_action(handle_req(ACT_ACQUIRE, 0, 0, 0, 0));
    issue_action(handle_req(ACT_PRECOMP, 0, 0, 0, 0));
    issue_action(handle_req(ACT_ABORT, 0, 0, 0, 0));
    // released on a free slot is illegal
    issue_action(handle_req(ACT_RELEASED, 0, 0, 0, 0));
    r = handle_req(ACT_INSPECT, NSLOT - 1, 0, 0, 0);
    r.generation_tag = 16'hFFFF;
    issue_action(r);
    r.action = ACT_UNUSED;
    issue_action(r);
    drain_outcomes();
  endtask

  // cycle slot 0 through acquire and abort back to back so its generation keeps climbing
  task automatic test_generation_bump();
    set_register(CFG_ALLOC_LIMIT, 4'd1);
    clear_pool();
    idle_on = 1'b0;
    repeat (30) begin
      issue_action(handle_req(ACT_ACQUIRE, 0, 0, 0, 0));
      issue_action(handle_req(ACT_ABORT, 0, 0, 0, 0));
    end
    drain_outcomes();
    idle_on = 1'b1;
  endtask

  task automatic run_random_phase(input logic [CFG_DATA_W-1:0] en_val,
                                  input logic [CFG_DATA_W-1:0] lim_val,
                                  input int count, input bit clear_first);
    drain_outcomes();
    set_register(CFG_POOL_ENABLED, en_val);
    set_register(CFG_ALLOC_LIMIT, lim_val);
    if (clear_first) clear_pool();
    for (int k = 0; k < count; k++) begin
      // hold off mid-phase until every response is back
      if (k == count / 2) drain_outcomes();
      issue_action(next_random_req());
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(4'd1, 4'd8, 300, 1'b0);
    run_random_phase(4'd1, 4'd3, 200, 1'b0);
    run_random_phase(4'd1, 4'd15, 250, 1'b0);
    run_random_phase(4'd1, 4'd0, 100, 1'b1);
    // only bit 0 of the enable write counts
    run_random_phase(4'b1110, 4'd8, 100, 1'b0);
    run_random_phase(4'd1, 4'd1, 150, 1'b0);
    run_random_phase(4'd1, 4'($urandom_range(7, 2)), 350, 1'b0);
    drain_outcomes();
  endtask

  initial begin
    item_if.valid           = 1'b0;
    item_if.action          = '0;
    item_if.slot_index      = '0;
    item_if.generation_tag  = '0;
    item_if.prev_valid      = 1'b0;
    item_if.prev_slot       = '0;
    item_if.prev_generation = '0;
    item_if.fence_ready     = 1'b0;
    result_if.ready         = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = '0;
    cfg_data_i              = '0;
    rst_ni                  = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_phase_q[i] = PH_FREE;
      slot_gen_q[i]   = '0;
      slot_rdy_q[i]   = 1'b0;
    end
    pool_en_q   = 1'b0;
    alloc_lim_q = LIMIT_RESET;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_pool();
    test_lifecycle();
    test_generation_bump();
    test_random_traffic();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
